FILE: rtl/bbvc_pkg.sv
// shared widths, types and register codes for the bounding box view cull core
package bbvc_pkg;

    localparam int COORD_W = 24;
    localparam int OFF_W   = COORD_W + 1;
    localparam int TRIG_W  = 16;
    localparam int PROD_W  = OFF_W + TRIG_W;
    localparam int UV_W    = PROD_W + 1;
    localparam int SUM_W   = UV_W + 1;
    localparam int CTR_W   = 12;
    localparam int SCR_W   = 13;
    localparam int CMP_W   = SUM_W + CTR_W + 1;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = COORD_W;
    localparam int NCORNER = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [OFF_W-1:0]   off_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [UV_W-1:0]    uv_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [CMP_W-1:0]   cmp_t;

    // one map unit at the scale of u and v
    localparam uv_t UNIT_Q22 = uv_t'(64'sd4194304);

    localparam coord_t VIEWER_RST = '0;
    localparam trig_t  SINE_RST   = '0;
    localparam trig_t  COSINE_RST = trig_t'(16384);
    localparam logic [CTR_W-1:0] CENTER_RST = CTR_W'(160);
    localparam logic [SCR_W-1:0] WIDTH_RST  = SCR_W'(320);

    typedef enum logic [IDX_W-1:0] {
        REG_VIEWER_X       = 3'd0,
        REG_VIEWER_Y       = 3'd1,
        REG_HEADING_SINE   = 3'd2,
        REG_HEADING_COSINE = 3'd3,
        REG_SCREEN_CENTER  = 3'd4,
        REG_SCREEN_WIDTH   = 3'd5
    } cfg_reg_t;

    // control that travels with each beat through the pipeline
    typedef struct packed {
        logic valid;
        logic split;
    } tag_t;

endpackage

FILE: rtl/bbvc_rotate.sv
// two-stage rotation of the four box corners into view space (u lateral, v depth)
module bbvc_rotate (
    input  logic            clk,
    input  logic            rst_n,
    input  bbvc_pkg::tag_t  tag_in,
    input  bbvc_pkg::off_t  dx1,
    input  bbvc_pkg::off_t  dy1,
    input  bbvc_pkg::off_t  dx2,
    input  bbvc_pkg::off_t  dy2,
    input  bbvc_pkg::trig_t sine,
    input  bbvc_pkg::trig_t cosine,
    output bbvc_pkg::tag_t  tag_out,
    output bbvc_pkg::uv_t   u_out [bbvc_pkg::NCORNER],
    output bbvc_pkg::uv_t   v_out [bbvc_pkg::NCORNER]
);
    import bbvc_pkg::*;

    tag_t  tag_p_reg;
    tag_t  tag_uv_reg;
    prod_t x1s_reg, x1c_reg, x2s_reg, x2c_reg;
    prod_t y1s_reg, y1c_reg, y2s_reg, y2c_reg;
    uv_t   u_reg [NCORNER];
    uv_t   v_reg [NCORNER];
    uv_t   u_next [NCORNER];
    uv_t   v_next [NCORNER];

    function automatic uv_t add_p(input prod_t a, input prod_t b);
        return {a[PROD_W-1], a} + {b[PROD_W-1], b};
    endfunction

    function automatic uv_t sub_p(input prod_t a, input prod_t b);
        return {a[PROD_W-1], a} - {b[PROD_W-1], b};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_p_reg  <= '0;
            tag_uv_reg <= '0;
        end
        else
        begin
            tag_p_reg  <= tag_in;
            tag_uv_reg <= tag_p_reg;
        end
    end

    // eight shared products feed all four corners
    always_ff @(posedge clk)
    begin
        x1s_reg <= prod_t'(dx1) * prod_t'(sine);
        x1c_reg <= prod_t'(dx1) * prod_t'(cosine);
        x2s_reg <= prod_t'(dx2) * prod_t'(sine);
        x2c_reg <= prod_t'(dx2) * prod_t'(cosine);
        y1s_reg <= prod_t'(dy1) * prod_t'(sine);
        y1c_reg <= prod_t'(dy1) * prod_t'(cosine);
        y2s_reg <= prod_t'(dy2) * prod_t'(sine);
        y2c_reg <= prod_t'(dy2) * prod_t'(cosine);
    end

    // corners: (x1,y1) (x2,y2) (x1,y2) (x2,y1)
    always_comb
    begin
        v_next[0] = add_p(x1s_reg, y1c_reg);
        u_next[0] = sub_p(x1c_reg, y1s_reg);
        v_next[1] = add_p(x2s_reg, y2c_reg);
        u_next[1] = sub_p(x2c_reg, y2s_reg);
        v_next[2] = add_p(x1s_reg, y2c_reg);
        u_next[2] = sub_p(x1c_reg, y2s_reg);
        v_next[3] = add_p(x2s_reg, y1c_reg);
        u_next[3] = sub_p(x2c_reg, y1s_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NCORNER; k++)
        begin
            u_reg[k] <= u_next[k];
            v_reg[k] <= v_next[k];
        end
    end

    assign tag_out = tag_uv_reg;

    always_comb
    begin
        for (int k = 0; k < NCORNER; k++)
        begin
            u_out[k] = u_reg[k];
            v_out[k] = v_reg[k];
        end
    end

endmodule

FILE: rtl/bounding_box_view_cull_core.sv
// top level: config registers and six-stage view cull pipeline for one box per beat
//
//  channel  signals                               direction  handshake
//  cmd      start, busy, is_split, pick_right,    in         start & !busy
//           left_*/right_* corners
//  result   done, visible                         out        done, one cycle, no hold-off
//  cfg      cfg_valid, cfg_ready, cfg_index,      in         cfg_valid & cfg_ready
//           cfg_data
//
// one beat accepted every cycle; busy stays low
// results leave the result register in the order their beats were accepted
// stages: corner offsets, products, u/v sums, near/behind flags and u+v,
//   projection products, compare and result register
// rst_n clears all valid bits and loads the register defaults
// the receiver cannot stall, so nothing inside ever holds
module bounding_box_view_cull_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    is_split,
    input  logic                                    pick_right,
    input  bbvc_pkg::coord_t                        left_ax,
    input  bbvc_pkg::coord_t                        left_ay,
    input  bbvc_pkg::coord_t                        left_bx,
    input  bbvc_pkg::coord_t                        left_by,
    input  bbvc_pkg::coord_t                        right_ax,
    input  bbvc_pkg::coord_t                        right_ay,
    input  bbvc_pkg::coord_t                        right_bx,
    input  bbvc_pkg::coord_t                        right_by,
    output logic                                    done,
    output logic                                    visible,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bbvc_pkg::IDX_W-1:0]              cfg_index,
    input  logic [bbvc_pkg::CFG_W-1:0]              cfg_data
);
    import bbvc_pkg::*;

    coord_t             viewer_x_reg;
    coord_t             viewer_y_reg;
    trig_t              sine_reg;
    trig_t              cosine_reg;
    logic [CTR_W-1:0]   center_reg;
    logic [SCR_W-1:0]   width_reg;

    // stage 1
    tag_t   tag1_reg;
    off_t   dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    coord_t sel_ax, sel_ay, sel_bx, sel_by;

    // stages 2 and 3
    tag_t   tag3;
    uv_t    u3 [NCORNER];
    uv_t    v3 [NCORNER];

    // stage 4
    tag_t   tag4_reg;
    logic   all_near_reg;
    logic   any_behind_reg;
    sum_t   uvs_reg [NCORNER];
    uv_t    v4_reg  [NCORNER];
    logic   all_near_next;
    logic   any_behind_next;

    // stage 5
    tag_t   tag5_reg;
    logic   near5_reg;
    logic   behind5_reg;
    logic   all_left_reg;
    cmp_t   num_reg [NCORNER];
    cmp_t   wv_reg  [NCORNER];
    logic   all_left_next;
    logic signed [CTR_W:0] xp_s;
    logic signed [SCR_W:0] w_s;

    // stage 6
    logic   done_reg;
    logic   visible_reg;
    logic   all_right;
    logic   visible_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg <= VIEWER_RST;
            viewer_y_reg <= VIEWER_RST;
            sine_reg     <= SINE_RST;
            cosine_reg   <= COSINE_RST;
            center_reg   <= CENTER_RST;
            width_reg    <= WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VIEWER_X:       viewer_x_reg <= cfg_data[COORD_W-1:0];
                REG_VIEWER_Y:       viewer_y_reg <= cfg_data[COORD_W-1:0];
                REG_HEADING_SINE:   sine_reg     <= cfg_data[TRIG_W-1:0];
                REG_HEADING_COSINE: cosine_reg   <= cfg_data[TRIG_W-1:0];
                REG_SCREEN_CENTER:  center_reg   <= cfg_data[CTR_W-1:0];
                REG_SCREEN_WIDTH:   width_reg    <= cfg_data[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- stage 1: pick the box and take corners relative to the viewer
    always_comb
    begin
        sel_ax = pick_right ? right_ax : left_ax;
        sel_ay = pick_right ? right_ay : left_ay;
        sel_bx = pick_right ? right_bx : left_bx;
        sel_by = pick_right ? right_by : left_by;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag1_reg <= '0;
        else
        begin
            tag1_reg.valid <= start && !busy;
            tag1_reg.split <= is_split;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg <= {sel_ax[COORD_W-1], sel_ax} - {viewer_x_reg[COORD_W-1], viewer_x_reg};
        dy1_reg <= {sel_ay[COORD_W-1], sel_ay} - {viewer_y_reg[COORD_W-1], viewer_y_reg};
        dx2_reg <= {sel_bx[COORD_W-1], sel_bx} - {viewer_x_reg[COORD_W-1], viewer_x_reg};
        dy2_reg <= {sel_by[COORD_W-1], sel_by} - {viewer_y_reg[COORD_W-1], viewer_y_reg};
    end

    // ---- stages 2 and 3: rotation
    bbvc_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag1_reg),
        .dx1     (dx1_reg),
        .dy1     (dy1_reg),
        .dx2     (dx2_reg),
        .dy2     (dy2_reg),
        .sine    (sine_reg),
        .cosine  (cosine_reg),
        .tag_out (tag3),
        .u_out   (u3),
        .v_out   (v3)
    );

    // ---- stage 4: depth flags and u+v for the projection
    always_comb
    begin
        all_near_next   = 1'b1;
        any_behind_next = 1'b0;
        for (int k = 0; k < NCORNER; k++)
        begin
            if (v3[k] > UNIT_Q22)
                all_near_next = 1'b0;
            if (v3[k] <= uv_t'(0))
                any_behind_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag4_reg <= '0;
        else
            tag4_reg <= tag3;
    end

    always_ff @(posedge clk)
    begin
        all_near_reg   <= all_near_next;
        any_behind_reg <= any_behind_next;
        for (int k = 0; k < NCORNER; k++)
        begin
            uvs_reg[k] <= {u3[k][UV_W-1], u3[k]} + {v3[k][UV_W-1], v3[k]};
            v4_reg[k]  <= v3[k];
        end
    end

    // ---- stage 5: cross-multiplied projection, left test needs only the sign of u+v and a nonzero center
    assign xp_s = $signed({1'b0, center_reg});
    assign w_s  = $signed({1'b0, width_reg});

    always_comb
    begin
        all_left_next = (center_reg != '0);
        for (int k = 0; k < NCORNER; k++)
        begin
            if (!uvs_reg[k][SUM_W-1])
                all_left_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag5_reg <= '0;
        else
            tag5_reg <= tag4_reg;
    end

    always_ff @(posedge clk)
    begin
        near5_reg    <= all_near_reg;
        behind5_reg  <= any_behind_reg;
        all_left_reg <= all_left_next;
        for (int k = 0; k < NCORNER; k++)
        begin
            num_reg[k] <= cmp_t'(xp_s) * cmp_t'(uvs_reg[k]);
            wv_reg[k]  <= cmp_t'(w_s) * cmp_t'(v4_reg[k]);
        end
    end

    // ---- stage 6: decision
    always_comb
    begin
        all_right = 1'b1;
        for (int k = 0; k < NCORNER; k++)
        begin
            if (num_reg[k] < wv_reg[k])
                all_right = 1'b0;
        end
        if (!tag5_reg.split)
            visible_next = 1'b1;
        else if (near5_reg)
            visible_next = 1'b0;
        else if (behind5_reg)
            visible_next = 1'b1;
        else
            visible_next = !(all_left_reg || all_right);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tag5_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
    end

    assign done    = done_reg;
    assign visible = visible_reg;

    // ---- checks
    // every accepted beat yields its result at the end of the pipeline
    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted beat produced no result");

    // no result without a beat accepted at the pipeline entry
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without an accepted beat");

    // a leaf node is always reported visible
    a_leaf_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !is_split) |-> ##6 visible)
        else $error("leaf node reported culled");

    // stage 5: a split box with every corner at most one unit deep is culled
    a_near_culled: assert property (@(posedge clk) disable iff (!rst_n)
        (tag5_reg.valid && tag5_reg.split && near5_reg) |=> (done && !visible))
        else $error("near box not culled");

endmodule
